### rtl/core/boew_pkg.sv
// ----------------------------------------------------------------------------
// boew_pkg
// Shared types and codes for the box overlap edge weight core.
// ----------------------------------------------------------------------------
package boew_pkg;

	localparam int ID_BITS = 24;
	localparam int STATUS_BITS = 2;

	typedef enum logic [1:0] {
		ST_EDGE  = 2'd0,
		ST_SMALL = 2'd1,
		ST_NONE  = 2'd2
	} status_t;

	localparam logic [31:0] AREA_FLOOR_RESET = 32'd25;

	typedef struct packed {
		logic [ID_BITS-1:0] src;
		logic [ID_BITS-1:0] dst;
	} tag_t;

endpackage

### rtl/core/boew_divider.sv
// ----------------------------------------------------------------------------
// boew_divider
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
// ----------------------------------------------------------------------------
module boew_divider #(
	parameter int W    = 36,
	parameter int Q    = 16,
	parameter int SB   = 2 + 2 * boew_pkg::ID_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [SB-1:0] in_side,
	input  logic [W-1:0]  in_num,
	input  logic [W-1:0]  in_den,
	input  logic          in_full,
	output logic          out_valid,
	output logic [SB-1:0] out_side,
	output logic [Q:0]    out_quot
);

	logic            vld_s  [Q+1];
	logic [SB-1:0]   side_s [Q+1];
	logic [W:0]      rem_s  [Q+1];
	logic [W-1:0]    den_s  [Q+1];
	logic [Q-1:0]    quo_s  [Q+1];
	logic            full_s [Q+1];

	always_comb begin
		vld_s[0]  = in_valid;
		side_s[0] = in_side;
		rem_s[0]  = {1'b0, in_num};
		den_s[0]  = in_den;
		quo_s[0]  = '0;
		full_s[0] = in_full;
	end

	for (genvar i = 0; i < Q; i++) begin : g_stage
		logic [W+1:0] sh;
		logic         ge;
		assign sh = {rem_s[i], 1'b0};
		assign ge = sh >= {2'b00, den_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				den_s[i+1]  <= den_s[i];
				full_s[i+1] <= full_s[i];
				rem_s[i+1]  <= ge ? (W+1)'(sh - {2'b00, den_s[i]}) : sh[W:0];
				quo_s[i+1]  <= {quo_s[i][Q-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[Q];
	assign out_side  = side_s[Q];
	assign out_quot  = full_s[Q] ? (Q+1)'(1) << Q : {1'b0, quo_s[Q]};

endmodule

### rtl/core/box_overlap_edge_weight_core.sv
// ----------------------------------------------------------------------------
// box_overlap_edge_weight_core
// Intersection over union of two boxes, one word per cycle unless m_axis stalls.
//
// channel   dir  contents
// s_axis    in   ids and corners of two boxes
// m_axis    out  status, edge ids, Q1.F weight
// cfg       in   area floor write
//
// One word per cycle sustained unless m_axis stalls; words pass through the
// extents, products and classify stages, then the one-bit-per-stage divider.
// Reset clears valid bits and loads the area floor with 25.
// A stall on m_axis freezes the whole pipeline; the last stage doubles as
// the output register.
// ----------------------------------------------------------------------------
module box_overlap_edge_weight_core #(
	parameter int COORD_BITS = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// src_id, dst_id, a_left, a_top, a_right, a_bottom, b_left..b_bottom
	input  logic [48+8*COORD_BITS-1:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// edge_src, edge_dst, weight, zero fill
	output logic [((48+WEIGHT_FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata,
	// status
	output logic [1:0]  m_axis_tuser
);

	localparam int C  = COORD_BITS;
	localparam int IB = boew_pkg::ID_BITS;
	localparam int DB = C + 1;
	localparam int AB = 2 * DB;
	localparam int UB = AB + 1;
	localparam int MB = (AB + 1 > 34) ? AB + 1 : 34;
	localparam int SB = 2 + 2 * IB;
	localparam int Q  = WEIGHT_FRAC_BITS;
	localparam int OB = ((2*IB+Q+1+7)/8)*8;

	logic [31:0] area_floor_q;
	logic        en;
	logic        out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_floor_q <= boew_pkg::AREA_FLOOR_RESET;
		end else if (cfg_we) begin
			area_floor_q <= cfg_wdata;
		end
	end

	assign en = m_axis_tready || !out_valid;
	assign s_axis_tready = en;

	logic signed [C-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
	assign ax1 = s_axis_tdata[2*IB+0*C +: C];
	assign ay1 = s_axis_tdata[2*IB+1*C +: C];
	assign ax2 = s_axis_tdata[2*IB+2*C +: C];
	assign ay2 = s_axis_tdata[2*IB+3*C +: C];
	assign bx1 = s_axis_tdata[2*IB+4*C +: C];
	assign by1 = s_axis_tdata[2*IB+5*C +: C];
	assign bx2 = s_axis_tdata[2*IB+6*C +: C];
	assign by2 = s_axis_tdata[2*IB+7*C +: C];

	// stage 1: extents
	boew_pkg::tag_t tag_s1, tag_s2, tag_s3;
	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [DB-1:0] aw_s1, ah_s1, bw_s1, bh_s1, ow_s1, oh_s1;
	logic                 ov_s1;

	logic signed [C-1:0] xmax, xmin, ymax, ymin;
	assign xmax = (ax2 < bx2) ? ax2 : bx2;
	assign xmin = (ax1 > bx1) ? ax1 : bx1;
	assign ymax = (ay2 < by2) ? ay2 : by2;
	assign ymin = (ay1 > by1) ? ay1 : by1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1.src <= s_axis_tdata[0 +: IB];
			tag_s1.dst <= s_axis_tdata[IB +: IB];
			aw_s1 <= DB'(ax2) - DB'(ax1);
			ah_s1 <= DB'(ay2) - DB'(ay1);
			bw_s1 <= DB'(bx2) - DB'(bx1);
			bh_s1 <= DB'(by2) - DB'(by1);
			ow_s1 <= DB'(xmax) - DB'(xmin);
			oh_s1 <= DB'(ymax) - DB'(ymin);
			ov_s1 <= (xmax > xmin) && (ymax > ymin);
		end
	end

	// stage 2: products
	logic signed [AB-1:0] area_a_s2, area_b_s2, inter_s2;
	logic                 ov_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2.src <= tag_s1.src;
			tag_s2.dst <= tag_s1.dst;
			area_a_s2  <= ah_s1 * aw_s1;
			area_b_s2  <= bh_s1 * bw_s1;
			inter_s2   <= ow_s1 * oh_s1;
			ov_s2      <= ov_s1;
		end
	end

	// stage 3: classify and union
	logic signed [MB-1:0] min_s;
	logic                 below_floor;
	assign min_s = MB'({1'b0, area_floor_q});
	assign below_floor = MB'(area_a_s2) < min_s || MB'(area_b_s2) < min_s;

	logic [1:0]     st_s3;
	logic [UB-1:0]  num_s3, den_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3.src <= tag_s2.src;
			tag_s3.dst <= tag_s2.dst;
			st_s3 <= below_floor ? boew_pkg::ST_SMALL : (ov_s2 ? boew_pkg::ST_EDGE
			       : boew_pkg::ST_NONE);
			num_s3 <= UB'(inter_s2);
			den_s3 <= UB'(area_a_s2) + UB'(area_b_s2) - UB'(inter_s2);
		end
	end

	// divider stages
	logic [SB-1:0] side_out;
	logic [Q:0]    quot;
	boew_divider #(.W(UB), .Q(Q), .SB(SB)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s3),
		.in_side({st_s3, tag_s3.dst, tag_s3.src}),
		.in_num(num_s3), .in_den(den_s3),
		.in_full(num_s3 >= den_s3),
		.out_valid(out_valid), .out_side(side_out), .out_quot(quot)
	);

	logic [1:0] st_out;
	assign st_out = side_out[SB-1 -: 2];
	assign m_axis_tvalid = out_valid;
	assign m_axis_tuser  = st_out;
	assign m_axis_tdata  = OB'({(st_out == boew_pkg::ST_EDGE) ? quot : {(Q+1){1'b0}},
		side_out[2*IB-1:0]});

endmodule

### rtl/core/boew_checker.sv
// ----------------------------------------------------------------------------
// boew_checker
// Port-level checks for the box overlap edge weight core.
// ----------------------------------------------------------------------------
module boew_checker #(
	parameter int OB = 72
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_axis_tready,
	input logic          m_axis_tvalid,
	input logic          m_axis_tready,
	input logic [OB-1:0] m_axis_tdata,
	input logic [1:0]    m_axis_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word dropped or changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output empty");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= boew_pkg::ST_NONE)
		else $error("bad status");

	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != boew_pkg::ST_EDGE |-> m_axis_tdata[OB-1:48] == '0)
		else $error("weight set without edge");

endmodule

bind box_overlap_edge_weight_core boew_checker #(.OB($bits(m_axis_tdata))) u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
